>>> hw/rtl/go_to_goal_velocity_controller_unit_defines.svh
// Assertion helpers shared by the controller RTL.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define GTG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define GTG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gtg_pkg.sv
`timescale 1ns / 1ps
package gtg_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_THR = 4'd1;

    // Reset values of the thresholds, Q8.16 meters.
    localparam logic [23:0] STOP_THR_RST  = 24'd49152;
    localparam logic [23:0] POINT_THR_RST = 24'd52429;

    // Fixed constants of the control law.
    localparam logic [28:0] ARRIVE_Q16   = 29'd85197;
    localparam logic [23:0] MIN_STOP_Q16 = 24'd19661;
    localparam logic [23:0] MIN_DEN_Q16  = 24'd66;
    localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;
    localparam int          PI_Q16       = 205887;
    localparam int          PI_Q13       = 25736;
    localparam int          CORDIC_STEPS = 17;

    // Internal datapath widths.
    localparam int ACC_W = 58;   // rotation accumulator
    localparam int EX_W  = 30;   // robot-frame offset
    localparam int ABS_W = 29;   // offset magnitude
    localparam int CRD_W = 48;   // vectoring x and y
    localparam int Z_W   = 20;   // vectoring angle, Q.16
    localparam int SQ_W  = 58;   // sum of squares
    localparam int RT_W  = 29;   // square root
    localparam int RM_W  = 32;   // square root remainder
    localparam int DV_W  = 28;   // divisor
    localparam int PR_W  = 48;   // distance times scale numerator

    typedef struct packed {
        logic signed [23:0] robot_x;
        logic signed [23:0] robot_y;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_z;
        logic        [23:0] obs_dist;
        logic               obstacle_valid;
    } t_req;

    typedef struct packed {
        logic        [23:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic        [23:0] goal_distance;
        logic signed [15:0] heading;
        logic               point_now;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [23:0]          value;
    } t_cfg;

    // Arctangent of 2^-i in Q.16 radians.
    function automatic logic [15:0] f_atan(input logic [4:0] i);
        logic [15:0] v;
        unique case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/gtg_if.sv
`timescale 1ns / 1ps
// Request channel carrying one pose item.
interface gtg_req_if;
    import gtg_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Response channel carrying one velocity command.
interface gtg_rsp_if;
    import gtg_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface gtg_cfg_if;
    import gtg_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/go_to_goal_velocity_controller_unit.sv
// A request runs in turn through the bit-serial rotation multiply, the serial squaring,
// the two-bit-per-cycle square root, and the serial scale multiply and restoring divide;
// a new request is taken only in idle with no result pending. The next request can be
// taken while a response waits in the output register. Synchronous active-low reset
// clears control state and reloads the threshold defaults.
`timescale 1ns / 1ps
`include "go_to_goal_velocity_controller_unit_defines.svh"
module go_to_goal_velocity_controller_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gtg_req_if.sink       i_req,
    gtg_rsp_if.source     o_rsp,
    gtg_cfg_if.sink       i_cfg
);
    import gtg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ROT, S_RND, S_SQ, S_SQRT, S_SCL, S_MUL, S_DIV
    } t_state;

    t_state r_state;
    logic [4:0] r_cnt;

    logic [23:0] r_stop, r_point;
    logic        r_pt_done;

    logic [24:0] r_dx, r_dy;
    logic signed [33:0] r_c, r_s;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic [23:0] r_obs;
    logic        r_obs_ok;

    logic [ABS_W-1:0] r_ax, r_ay, r_sx, r_sy;
    logic             r_zero;
    logic signed [CRD_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0]   r_cz;
    logic [SQ_W-1:0] r_sq;

    logic [RT_W-1:0] r_root;
    logic [RM_W-1:0] r_rem;

    logic signed [15:0] r_head;
    logic [18:0] r_angv;
    logic        r_ang_neg;
    logic [14:0] r_angq;

    logic [23:0]     r_d, r_num;
    logic [DV_W-1:0] r_div;
    logic [PR_W-1:0] r_prod;
    logic [DV_W:0]   r_dr;
    logic [23:0]     r_quo;
    logic            r_pt;
    logic            r_pend;

    logic r_o_valid;
    t_rsp r_o_data;

    // Handshakes.
    logic w_acc, w_cfg, w_out_free;
    assign w_acc      = i_req.valid && i_req.ready;
    assign w_cfg      = i_cfg.valid && i_cfg.ready;
    assign w_out_free = !r_o_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_pend;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o_data;

    // Rotation coefficients, Q.28.
    logic signed [33:0] w_c, w_s;
    assign w_c = 34'sd268435456 - 34'(i_req.data.quat_z * i_req.data.quat_z) * 34'sd2;
    assign w_s = 34'(i_req.data.quat_w * i_req.data.quat_z) * 34'sd2;

    // One bit of dx and dy per cycle, sign bit first with negative weight.
    logic signed [ACC_W-1:0] w_cx_t, w_sx_t, w_cy_t, w_sy_t;
    logic w_msb;
    assign w_msb  = (r_cnt == 5'd0);
    assign w_cx_t = r_dx[24] ? (w_msb ? -ACC_W'(r_c) : ACC_W'(r_c)) : '0;
    assign w_sx_t = r_dx[24] ? (w_msb ? -ACC_W'(r_s) : ACC_W'(r_s)) : '0;
    assign w_cy_t = r_dy[24] ? (w_msb ? -ACC_W'(r_c) : ACC_W'(r_c)) : '0;
    assign w_sy_t = r_dy[24] ? (w_msb ? -ACC_W'(r_s) : ACC_W'(r_s)) : '0;

    // Round the robot-frame offset half up to Q14.16.
    logic signed [ACC_W-1:0] w_rx, w_ry;
    logic signed [EX_W-1:0]  w_ex, w_ey;
    logic signed [CRD_W-1:0] w_ex_c, w_ey_c;
    assign w_rx   = r_acc_x + 58'sd134217728;
    assign w_ry   = r_acc_y + 58'sd134217728;
    assign w_ex   = w_rx[ACC_W-1:28];
    assign w_ey   = w_ry[ACC_W-1:28];
    assign w_ex_c = CRD_W'(w_ex) <<< 16;
    assign w_ey_c = CRD_W'(w_ey) <<< 16;

    // Serial squaring of both magnitudes.
    logic [SQ_W-1:0] w_sq_next;
    assign w_sq_next = (r_sq << 1) + (r_sx[ABS_W-1] ? SQ_W'(r_ax) : '0)
                     + (r_sy[ABS_W-1] ? SQ_W'(r_ay) : '0);

    // One vectoring step of the angle unit.
    logic signed [CRD_W-1:0] w_xs, w_ys;
    logic signed [Z_W-1:0]   w_atan;
    assign w_xs   = r_cx >>> r_cnt;
    assign w_ys   = r_cy >>> r_cnt;
    assign w_atan = $signed({4'b0, f_atan(r_cnt)});

    // Heading rounded to Q3.13 and clamped to plus or minus pi.
    logic signed [Z_W-1:0] w_zr;
    logic signed [15:0]    w_head;
    assign w_zr = (r_cz + 20'sd4) >>> 3;
    always_comb begin
        priority if (r_zero) begin
            w_head = '0;
        end else if (w_zr > 20'(PI_Q13)) begin
            w_head = 16'(PI_Q13);
        end else if (w_zr < -20'(PI_Q13)) begin
            w_head = -16'(PI_Q13);
        end else begin
            w_head = w_zr[15:0];
        end
    end

    // Angular speed: 11/10 of heading via a reciprocal multiply.
    logic signed [19:0] w_p;
    logic [18:0]        w_pabs;
    logic [38:0]        w_angm;
    assign w_p    = 20'(r_head) * 20'sd11;
    assign w_pabs = w_p[19] ? 19'(-w_p) : w_p[18:0];
    assign w_angm = 39'(r_angv) * 39'd838861;

    // Square root step: two bits of the radicand per cycle.
    logic [RM_W-1:0] w_rem_sh, w_trial;
    assign w_rem_sh = {r_rem[RM_W-3:0], r_sq[SQ_W-1:SQ_W-2]};
    assign w_trial  = RM_W'({r_root, 2'b01});

    // Distance with arrival zone and saturation, then scale terms.
    logic [23:0] w_d, w_den;
    logic        w_scale;
    assign w_d = (r_root <= ARRIVE_Q16) ? '0
               : ((r_root > RT_W'(DIST_MAX)) ? DIST_MAX : r_root[23:0]);
    assign w_scale = r_obs_ok && (r_obs < r_stop);
    assign w_den   = (r_stop >= MIN_STOP_Q16 + MIN_DEN_Q16) ? r_stop - MIN_STOP_Q16
                   : MIN_DEN_Q16;

    // Serial product and restoring division.
    logic [PR_W-1:0] w_prod_next;
    logic [DV_W:0]   w_dt;
    assign w_prod_next = {r_prod[PR_W-2:0], 1'b0} + (r_num[23] ? PR_W'(r_d) : '0);
    assign w_dt        = {r_dr[DV_W-1:0], r_prod[23]};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop  <= STOP_THR_RST;
            r_point <= POINT_THR_RST;
        end else if (w_cfg) begin
            unique case (i_cfg.data.index)
                CFG_STOP_THR:  r_stop  <= i_cfg.data.value;
                CFG_POINT_THR: r_point <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pt_done <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (r_pend && w_out_free) begin
                        r_o_valid               <= 1'b1;
                        r_o_data.linear_speed   <= r_quo;
                        r_o_data.angular_speed  <= r_ang_neg ? -16'(r_angq) : 16'(r_angq);
                        r_o_data.goal_distance  <= r_d;
                        r_o_data.heading        <= r_head;
                        r_o_data.point_now      <= r_pt;
                        r_pend                  <= 1'b0;
                    end else if (w_acc) begin
                        r_dx     <= 25'(i_req.data.target_x) - 25'(i_req.data.robot_x);
                        r_dy     <= 25'(i_req.data.target_y) - 25'(i_req.data.robot_y);
                        r_c      <= w_c;
                        r_s      <= w_s;
                        r_obs    <= i_req.data.obs_dist;
                        r_obs_ok <= i_req.data.obstacle_valid;
                        r_acc_x  <= '0;
                        r_acc_y  <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_acc_x <= (r_acc_x <<< 1) + w_cx_t + w_sy_t;
                    r_acc_y <= (r_acc_y <<< 1) + w_cy_t - w_sx_t;
                    r_dx    <= {r_dx[23:0], 1'b0};
                    r_dy    <= {r_dy[23:0], 1'b0};
                    if (r_cnt == 5'd24) begin
                        r_state <= S_RND;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_RND: begin
                    r_ax   <= w_ex[EX_W-1] ? ABS_W'(-w_ex) : ABS_W'(w_ex);
                    r_ay   <= w_ey[EX_W-1] ? ABS_W'(-w_ey) : ABS_W'(w_ey);
                    r_sx   <= w_ex[EX_W-1] ? ABS_W'(-w_ex) : ABS_W'(w_ex);
                    r_sy   <= w_ey[EX_W-1] ? ABS_W'(-w_ey) : ABS_W'(w_ey);
                    r_zero <= (w_ex == '0) && (w_ey == '0);
                    if (w_ex[EX_W-1]) begin
                        r_cx <= -w_ex_c;
                        r_cy <= -w_ey_c;
                        r_cz <= w_ey[EX_W-1] ? -20'(PI_Q16) : 20'(PI_Q16);
                    end else begin
                        r_cx <= w_ex_c;
                        r_cy <= w_ey_c;
                        r_cz <= '0;
                    end
                    r_sq    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq <= w_sq_next;
                    r_sx <= {r_sx[ABS_W-2:0], 1'b0};
                    r_sy <= {r_sy[ABS_W-2:0], 1'b0};
                    // The angle unit runs alongside the squaring.
                    if (r_cnt < 5'(CORDIC_STEPS)) begin
                        if (r_cy > 0) begin
                            r_cx <= r_cx + w_ys;
                            r_cy <= r_cy - w_xs;
                            r_cz <= r_cz + w_atan;
                        end else begin
                            r_cx <= r_cx - w_ys;
                            r_cy <= r_cy + w_xs;
                            r_cz <= r_cz - w_atan;
                        end
                    end
                    if (r_cnt == 5'(ABS_W - 1)) begin
                        r_head  <= w_head;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQRT: begin
                    r_sq <= {r_sq[SQ_W-3:0], 2'b00};
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[RT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[RT_W-2:0], 1'b0};
                    end
                    // Angular speed: magnitude and sign first, then the scaled value.
                    if (r_cnt == 5'd0) begin
                        r_angv    <= w_pabs + 19'd5;
                        r_ang_neg <= w_p[19];
                    end
                    if (r_cnt == 5'd1) begin
                        r_angq <= w_angm[37:23];
                    end
                    if (r_cnt == 5'(RT_W - 1)) begin
                        r_state <= S_SCL;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SCL: begin
                    r_d <= w_d;
                    if (w_scale) begin
                        r_num <= (r_obs > MIN_STOP_Q16) ? r_obs - MIN_STOP_Q16 : '0;
                        r_div <= (DV_W'(w_den) << 3) + (DV_W'(w_den) << 1);
                    end else begin
                        r_num <= 24'd1;
                        r_div <= DV_W'(10);
                    end
                    // Pointing latch fires once and re-arms above the threshold.
                    if (w_d > r_point) begin
                        r_pt_done <= 1'b0;
                        r_pt      <= 1'b0;
                    end else begin
                        r_pt      <= !r_pt_done;
                        r_pt_done <= 1'b1;
                    end
                    r_prod  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= w_prod_next;
                    r_num  <= {r_num[22:0], 1'b0};
                    if (r_cnt == 5'd23) begin
                        r_dr    <= (DV_W + 1)'(w_prod_next[PR_W-1:24]);
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DIV: begin
                    r_prod <= {r_prod[PR_W-2:0], 1'b0};
                    if (w_dt >= (DV_W + 1)'(r_div)) begin
                        r_dr  <= w_dt - (DV_W + 1)'(r_div);
                        r_quo <= {r_quo[22:0], 1'b1};
                    end else begin
                        r_dr  <= w_dt;
                        r_quo <= {r_quo[22:0], 1'b0};
                    end
                    if (r_cnt == 5'd23) begin
                        r_pend  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer and the response.
    `GTG_ASSERT_NXT(a_accept_starts, w_acc, r_state == S_ROT, "accepted request did not start")
    `GTG_ASSERT_IMP(a_point_dist, r_o_valid && r_o_data.point_now, r_o_data.goal_distance <= r_point, "point pulse above threshold")
    `GTG_ASSERT_IMP(a_head_range, r_o_valid, (r_o_data.heading >= -16'sd25736) && (r_o_data.heading <= 16'sd25736), "heading out of range")
    `GTG_ASSERT_IMP(a_dist_zone, r_o_valid, (r_o_data.goal_distance == '0) || (29'(r_o_data.goal_distance) > ARRIVE_Q16), "distance inside arrival zone")
    `GTG_ASSERT_IMP(a_lin_bound, r_o_valid, r_o_data.linear_speed <= r_o_data.goal_distance, "speed exceeds distance")

endmodule
